[sv/cje_pkg.sv]
package cje_pkg;

  localparam int unsigned QFrac = 24;
  localparam int unsigned AWidth = 28;

  // |z|^2 bound of 10 in Q8.24
  localparam logic signed [32:0] EscLimit = 33'sd167772160;
  localparam logic [15:0] MaxIterReset = 16'd100;

  // configuration register indexes
  localparam logic [1:0] CFG_A_RE = 2'd0;
  localparam logic [1:0] CFG_A_IM = 2'd1;
  localparam logic [1:0] CFG_MAX_ITER = 2'd2;

  // multiplier operand selection
  localparam logic [2:0] MUL_RR = 3'd0;
  localparam logic [2:0] MUL_II = 3'd1;
  localparam logic [2:0] MUL_RI = 3'd2;
  localparam logic [2:0] MUL_T1DR = 3'd3;
  localparam logic [2:0] MUL_T2DI = 3'd4;
  localparam logic [2:0] MUL_T1DI = 3'd5;
  localparam logic [2:0] MUL_T2DR = 3'd6;

  // destination of the scaled product
  localparam logic [2:0] WB_NONE = 3'd0;
  localparam logic [2:0] WB_RE2 = 3'd1;
  localparam logic [2:0] WB_IM2 = 3'd2;
  localparam logic [2:0] WB_PREP = 3'd3;
  localparam logic [2:0] WB_M1 = 3'd4;
  localparam logic [2:0] WB_M2 = 3'd5;
  localparam logic [2:0] WB_M3 = 3'd6;
  localparam logic [2:0] WB_UPD = 3'd7;

  typedef struct packed {
    logic               func;
    logic signed [31:0] z_re;
    logic signed [31:0] z_im;
  } in_t;

  typedef struct packed {
    logic               bounded;
    logic [16:0]        escape_code;
    logic signed [31:0] new_re;
    logic signed [31:0] new_im;
  } out_t;

  typedef struct packed {
    logic       load_in;
    logic [2:0] mul_sel;
    logic [2:0] wb_sel;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic limit_hit;
    logic escaped;
  } status_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // floor shift by QFrac, then clamp to 32 bits
  function automatic logic signed [31:0] scale_prod(input logic signed [63:0] p);
    logic signed [31:0] r;
    if ((p[63:55] != '0) && (p[63:55] != '1)) begin
      r = p[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = p[55:24];
    end
    return r;
  endfunction

endpackage

[sv/cubic_julia_escape_time.sv]
// Escape-time engine for the cubic Julia map z -> z^2 * (z - a), Q8.24.
// Input channel (in_valid_i/in_ready_o, in_data_i): func selects an
// escape-time count (0) or a single map step (1) from the start point.
// Output channel (out_valid_o/out_ready_i, out_data_o): one result per input.
// Config channel (cfg_valid_i/cfg_ready_o): a_re, a_im, max_iter by index;
// always ready, write only while no item is in flight.
// One item is processed at a time. A map step issues seven products on the
// single shared 32x32 multiplier: three before the escape test and four
// before the update. A func 0 item stops once max_iter steps have run, or
// when the escape test of the step that would follow finds |z|^2 at or
// above the bound; a func 1 item runs a single map step.
// The result sits in an output register: the next input is taken while it
// waits, and a finished item holds in the engine while the receiver stalls.
// Reset clears the controller and sets a = 0, max_iter = 100.
module cubic_julia_escape_time (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cje_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cje_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i
);

  cje_pkg::cmd_t    cmd;
  cje_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  cje_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  cje_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (out_data_o)
  );

endmodule

[sv/cje_qmul.sv]
module cje_qmul (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [31:0] res_o
);

  logic signed [63:0] prod_d;
  logic signed [63:0] prod_q;

  assign prod_d = 64'(a_i) * 64'(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign res_o = cje_pkg::scale_prod(prod_q);

endmodule

[sv/cje_dp.sv]
module cje_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cje_pkg::cmd_t   cmd_i,
  output cje_pkg::status_t status_o,
  input  cje_pkg::in_t    in_data_i,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_index_i,
  input  logic [31:0]     cfg_data_i,
  output cje_pkg::out_t   out_data_o
);

  logic signed [cje_pkg::AWidth-1:0] a_re_q, a_im_q;
  logic [15:0] max_iter_q;

  logic               func_q;
  logic signed [31:0] cur_re_q, cur_im_q;
  logic [15:0]        n_q;
  logic signed [31:0] re2_q, im2_q;
  logic signed [31:0] t1_q, t2_q, dr_q, di_q;
  logic signed [31:0] m1_q, m2_q, m3_q;
  cje_pkg::out_t      out_q, out_d;

  logic signed [31:0] mul_a, mul_b, mul_res;
  logic signed [32:0] mag;
  logic signed [31:0] dr_d, di_d, t1_d, t2_d, new_re_d, new_im_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_re_q     <= '0;
      a_im_q     <= '0;
      max_iter_q <= cje_pkg::MaxIterReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cje_pkg::CFG_A_RE:     a_re_q <= cfg_data_i[cje_pkg::AWidth-1:0];
        cje_pkg::CFG_A_IM:     a_im_q <= cfg_data_i[cje_pkg::AWidth-1:0];
        cje_pkg::CFG_MAX_ITER: max_iter_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cmd_i.mul_sel)
      cje_pkg::MUL_II:   begin mul_a = cur_im_q; mul_b = cur_im_q; end
      cje_pkg::MUL_RI:   begin mul_a = cur_re_q; mul_b = cur_im_q; end
      cje_pkg::MUL_T1DR: begin mul_a = t1_q;     mul_b = dr_q;     end
      cje_pkg::MUL_T2DI: begin mul_a = t2_q;     mul_b = di_q;     end
      cje_pkg::MUL_T1DI: begin mul_a = t1_q;     mul_b = di_q;     end
      cje_pkg::MUL_T2DR: begin mul_a = t2_q;     mul_b = dr_q;     end
      default:           begin mul_a = cur_re_q; mul_b = cur_re_q; end
    endcase
  end

  cje_qmul u_qmul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .res_o (mul_res)
  );

  assign mag = 33'(re2_q) + 33'(im2_q);
  assign dr_d = cje_pkg::sat33(33'(cur_re_q) - 33'(a_re_q));
  assign di_d = cje_pkg::sat33(33'(cur_im_q) - 33'(a_im_q));
  assign t1_d = cje_pkg::sat33(33'(re2_q) - 33'(im2_q));
  // mul_res holds re*im here
  assign t2_d = cje_pkg::sat33({mul_res, 1'b0});
  assign new_re_d = cje_pkg::sat33(33'(m1_q) - 33'(m2_q));
  assign new_im_d = cje_pkg::sat33(33'(m3_q) + 33'(mul_res));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q   <= in_data_i.func;
      cur_re_q <= in_data_i.z_re;
      cur_im_q <= in_data_i.z_im;
      n_q      <= '0;
    end else begin
      unique case (cmd_i.wb_sel)
        cje_pkg::WB_RE2: re2_q <= mul_res;
        cje_pkg::WB_IM2: im2_q <= mul_res;
        cje_pkg::WB_PREP: begin
          t1_q <= t1_d;
          t2_q <= t2_d;
          dr_q <= dr_d;
          di_q <= di_d;
        end
        cje_pkg::WB_M1: m1_q <= mul_res;
        cje_pkg::WB_M2: m2_q <= mul_res;
        cje_pkg::WB_M3: m3_q <= mul_res;
        cje_pkg::WB_UPD: begin
          cur_re_q <= new_re_d;
          cur_im_q <= new_im_d;
          if (!func_q) begin
            n_q <= n_q + 16'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign status_o.func      = func_q;
  assign status_o.limit_hit = (n_q >= max_iter_q);
  assign status_o.escaped   = (mag >= cje_pkg::EscLimit);

  always_comb begin
    out_d = '0;
    if (func_q) begin
      out_d.new_re = cur_re_q;
      out_d.new_im = cur_im_q;
    end else if (status_o.limit_hit) begin
      out_d.bounded = 1'b1;
    end else begin
      out_d.escape_code = {n_q, 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

[sv/cje_ctrl.sv]
module cje_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cje_pkg::cmd_t    cmd_o,
  input  cje_pkg::status_t status_i
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RR   = 4'd1;
  localparam logic [3:0] S_II   = 4'd2;
  localparam logic [3:0] S_RI   = 4'd3;
  localparam logic [3:0] S_TEST = 4'd4;
  localparam logic [3:0] S_M1   = 4'd5;
  localparam logic [3:0] S_M2   = 4'd6;
  localparam logic [3:0] S_M3   = 4'd7;
  localparam logic [3:0] S_M4   = 4'd8;
  localparam logic [3:0] S_UPD  = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mul_sel = cje_pkg::MUL_RR;
    cmd_o.wb_sel  = cje_pkg::WB_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_RR;
        end
      end
      S_RR: begin
        if (!status_i.func && status_i.limit_hit) begin
          state_d = S_FIN;
        end else begin
          state_d = S_II;
        end
      end
      S_II: begin
        cmd_o.mul_sel = cje_pkg::MUL_II;
        cmd_o.wb_sel  = cje_pkg::WB_RE2;
        state_d       = S_RI;
      end
      S_RI: begin
        cmd_o.mul_sel = cje_pkg::MUL_RI;
        cmd_o.wb_sel  = cje_pkg::WB_IM2;
        state_d       = S_TEST;
      end
      S_TEST: begin
        cmd_o.wb_sel = cje_pkg::WB_PREP;
        if (!status_i.func && status_i.escaped) begin
          state_d = S_FIN;
        end else begin
          state_d = S_M1;
        end
      end
      S_M1: begin
        cmd_o.mul_sel = cje_pkg::MUL_T1DR;
        state_d       = S_M2;
      end
      S_M2: begin
        cmd_o.mul_sel = cje_pkg::MUL_T2DI;
        cmd_o.wb_sel  = cje_pkg::WB_M1;
        state_d       = S_M3;
      end
      S_M3: begin
        cmd_o.mul_sel = cje_pkg::MUL_T1DI;
        cmd_o.wb_sel  = cje_pkg::WB_M2;
        state_d       = S_M4;
      end
      S_M4: begin
        cmd_o.mul_sel = cje_pkg::MUL_T2DR;
        cmd_o.wb_sel  = cje_pkg::WB_M3;
        state_d       = S_UPD;
      end
      S_UPD: begin
        cmd_o.wb_sel = cje_pkg::WB_UPD;
        state_d      = status_i.func ? S_FIN : S_RR;
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.load_out || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[sv/cje_chk.sv]
module cje_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input cje_pkg::out_t out_data_o
);

  // one item at a time: a transfer closes the input side
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready while an item is in flight");

  // a result only appears while the engine is busy finishing an item
  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without an item in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

endmodule

bind cubic_julia_escape_time cje_chk u_cje_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
